// File: design/afd_pkg.sv
// Shared constants, types and codes for the addressed frame deframer.
`default_nettype none

package afd_pkg;

  // Payload buffer depth in bytes (1 to 64)
  localparam int MAX_PAYLOAD = 32;

  // Buffer index width and length counter width (holds MAX_PAYLOAD itself)
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int ADDR_W    = 16;
  localparam int FLEN_W    = 6;
  localparam int LIMIT_W   = 6;
  localparam int REG_IDX_W = 2;

  // Largest legal length as a byte value
  localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_PAYLOAD);

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0]  HEAD_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0]  TAIL_RST  = 8'h55;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(32);

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEAD  = 2'd0,
    REG_TAIL  = 2'd1,
    REG_LIMIT = 2'd2
  } afd_reg_t;

  // Parser position within a frame
  typedef enum logic [2:0] {
    PH_HEAD    = 3'd0,
    PH_ADDR_LO = 3'd1,
    PH_ADDR_HI = 3'd2,
    PH_LEN     = 3'd3,
    PH_DATA    = 3'd4,
    PH_TAIL    = 3'd5
  } afd_phase_t;

  // Replay sequencer states
  typedef enum logic [1:0] {
    RP_IDLE = 2'd0,
    RP_READ = 2'd1,
    RP_SHOW = 2'd2
  } afd_replay_t;

  // Parser to buffer: payload write and replay start
  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [BYTE_W-1:0]  wr_data;
    logic               start;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
  } afd_cmd_t;

endpackage

`default_nettype wire

// File: design/afd_replay.sv
// Payload buffer memory and the sequencer that replays an accepted frame.
`default_nettype none

module afd_replay (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire afd_pkg::afd_cmd_t         cmd,
  output logic                           busy,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [afd_pkg::ADDR_W-1:0]     source_address,
  output logic [afd_pkg::FLEN_W-1:0]     frame_length,
  output logic [afd_pkg::BYTE_W-1:0]     payload_byte,
  output logic                           last_byte
);
  import afd_pkg::*;

  // Payload store, one write and one registered read port
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data;

  afd_replay_t       state;
  afd_replay_t       state_next;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  idx_next;
  logic [LEN_W-1:0]  idx_inc;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] addr;
  logic              rd_en;
  logic              last;
  logic              taken;

  assign idx_inc = idx + LEN_W'(1);
  assign last    = (idx_inc == len);
  assign taken   = (state == RP_SHOW) && !out_stall;

  // Memory write and read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_idx] <= cmd.wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[idx[IDX_W-1:0]];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      RP_IDLE: begin
        if (cmd.start) begin
          state_next = RP_READ;
          idx_next   = '0;
        end
      end
      RP_READ: state_next = RP_SHOW;
      RP_SHOW: begin
        if (!out_stall) begin
          if (last) begin
            state_next = RP_IDLE;
          end else begin
            state_next = RP_READ;
            idx_next   = idx_inc;
          end
        end
      end
      default: state_next = RP_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rd_en     = 1'b0;
    out_valid = 1'b0;
    busy      = 1'b1;
    unique case (state)
      RP_IDLE: busy      = 1'b0;
      RP_READ: rd_en     = 1'b1;
      RP_SHOW: out_valid = 1'b1;
      default: busy      = 1'b1;
    endcase
  end

  assign source_address = addr;
  assign frame_length   = FLEN_W'(len);
  assign payload_byte   = rd_data;
  assign last_byte      = last;

  // Sequencer registers; frame header latched at start
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RP_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
    if (cmd.start && state == RP_IDLE) begin
      addr <= cmd.addr;
      len  <= cmd.len;
    end
  end

  // A replay only starts from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> state == RP_IDLE)
    else $error("replay started while busy");

  // No payload write lands during a replay
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> state == RP_IDLE)
    else $error("payload write during replay");

  // Shown index stays inside the frame
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx < len)
    else $error("replay index beyond frame length");

  // Last beat taken ends the replay
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    taken && last |=> state == RP_IDLE)
    else $error("replay did not end after last beat");

  // A beat that is not last leads to the next read
  a_next_read: assert property (@(posedge clk) disable iff (rst)
    taken && !last |=> state == RP_READ && idx == $past(idx_inc))
    else $error("replay skipped a byte");

endmodule

`default_nettype wire

// File: design/addressed_frame_deframer.sv
// Top level: frame parser, configuration registers and payload replay.
`default_nettype none

// Takes one received byte per beat and finds frames of the form head byte,
// 16-bit address (low byte first), length, payload, tail byte. Payload bytes
// go into a MAX_PAYLOAD-byte memory as they arrive. When the tail byte
// matches tail_value the stored payload is replayed, one output beat per
// byte with address, length and a last-byte mark; a mismatch drops the frame.
// After an accepted tail the input is stalled while the replay runs: each
// payload byte is first read from the memory and then shown, and the output
// stall can hold a shown byte. No clearing pass is needed after reset.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce.
module addressed_frame_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [afd_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [afd_pkg::BYTE_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [afd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [afd_pkg::ADDR_W-1:0]       source_address,
  output logic [afd_pkg::FLEN_W-1:0]       frame_length,
  output logic [afd_pkg::BYTE_W-1:0]       payload_byte,
  output logic                             last_byte
);
  import afd_pkg::*;

  logic [BYTE_W-1:0]  head_value;
  logic [BYTE_W-1:0]  tail_value;
  logic [LIMIT_W-1:0] payload_limit;

  afd_phase_t        phase;
  afd_phase_t        phase_next;
  logic [ADDR_W-1:0] frame_address;
  logic [ADDR_W-1:0] frame_address_next;
  logic [LEN_W-1:0]  expected_length;
  logic [LEN_W-1:0]  expected_length_next;
  logic [LEN_W-1:0]  byte_position;
  logic [LEN_W-1:0]  byte_position_next;
  logic [LEN_W-1:0]  pos_inc;

  logic      accept;
  logic      busy;
  logic      len_bad;
  afd_cmd_t  cmd;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign pos_inc  = byte_position + LEN_W'(1);
  assign len_bad  = (rx_byte == '0) || (rx_byte > {{(BYTE_W-LIMIT_W){1'b0}}, payload_limit})
                    || (rx_byte > MAX_LEN_B);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_value    <= HEAD_RST;
      tail_value    <= TAIL_RST;
      payload_limit <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HEAD:  head_value    <= cfg_data;
        REG_TAIL:  tail_value    <= cfg_data;
        REG_LIMIT: payload_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Parser next state
  always_comb begin
    phase_next           = phase;
    frame_address_next   = frame_address;
    expected_length_next = expected_length;
    byte_position_next   = byte_position;
    if (accept) begin
      unique case (phase)
        PH_HEAD: begin
          if (rx_byte == head_value) begin
            phase_next           = PH_ADDR_LO;
            frame_address_next   = '0;
            expected_length_next = '0;
            byte_position_next   = '0;
          end
        end
        PH_ADDR_LO: begin
          frame_address_next = {8'h00, rx_byte};
          phase_next         = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          frame_address_next = {rx_byte, frame_address[7:0]};
          phase_next         = PH_LEN;
        end
        PH_LEN: begin
          byte_position_next = '0;
          if (len_bad) begin
            phase_next           = PH_HEAD;
            frame_address_next   = '0;
            expected_length_next = '0;
          end else begin
            phase_next           = PH_DATA;
            expected_length_next = rx_byte[LEN_W-1:0];
          end
        end
        PH_DATA: begin
          byte_position_next = pos_inc;
          if (pos_inc >= expected_length) begin
            phase_next = PH_TAIL;
          end
        end
        default: begin
          // tail and unused codes both return to hunting
          phase_next           = PH_HEAD;
          frame_address_next   = '0;
          expected_length_next = '0;
          byte_position_next   = '0;
        end
      endcase
    end
  end

  // Parser outputs to the buffer
  always_comb begin
    cmd         = '0;
    cmd.wr_idx  = byte_position[IDX_W-1:0];
    cmd.wr_data = rx_byte;
    cmd.addr    = frame_address;
    cmd.len     = expected_length;
    unique case (phase)
      PH_DATA: cmd.wr_en = accept;
      PH_TAIL: cmd.start = accept && (rx_byte == tail_value);
      default: ;
    endcase
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEAD;
      frame_address   <= '0;
      expected_length <= '0;
      byte_position   <= '0;
    end else begin
      phase           <= phase_next;
      frame_address   <= frame_address_next;
      expected_length <= expected_length_next;
      byte_position   <= byte_position_next;
    end
  end

  afd_replay u_replay (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .source_address (source_address),
    .frame_length   (frame_length),
    .payload_byte   (payload_byte),
    .last_byte      (last_byte)
  );

  // Payload writes stay inside the declared length
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> byte_position < expected_length)
    else $error("payload position beyond length");

  // Accepted lengths are nonzero and at most MAX_PAYLOAD
  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> expected_length != '0 && expected_length <= LEN_W'(MAX_PAYLOAD))
    else $error("illegal stored length");

  // The tail byte always returns the parser to hunting
  a_tail_done: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_TAIL |=> phase == PH_HEAD)
    else $error("parser did not return after tail");

endmodule

`default_nettype wire
